// ----- rtl/core/hse_pkg.sv -----
// ----------------------------------------------------------------------------
// hse_pkg: shared definitions for the heap sort engine
// Element width, chain depth and the control bundle that drives the cells.
// ----------------------------------------------------------------------------
package hse_pkg;

	// Number of cells in the chain, which is the largest batch that is kept.
	localparam int DEPTH = 64;

	// Width of one element.
	localparam int WORD_W = 32;

	typedef logic signed [WORD_W-1:0] word_t;

	// Control that the top level broadcasts to every cell in a cycle.
	typedef struct packed {
		logic insert;   // place the broadcast element into the sorted chain
		logic shift;    // move every element one cell toward the output
	} chain_ctrl_t;

endpackage

// ----- rtl/core/heap_sort_engine.sv -----
// ----------------------------------------------------------------------------
// heap_sort_engine: batch sorter for signed 32-bit elements, ascending order
// A linear chain of insertion cells that emits the batch smallest first.
// ----------------------------------------------------------------------------
// The engine collects a batch of signed elements, one per input transaction,
// and returns them in ascending order once the transaction flagged last has
// been taken. Each element is broadcast to a chain of hse_pkg::DEPTH cells,
// and every cell compares it with its own element in the same cycle, so the
// chain stays sorted at all times and no separate sort pass is needed. After
// the last element the input stalls and the chain drains from cell zero, one
// result transaction per cycle while the output is not stalled; the input is
// taken again in the cycle after the final result. Every element enters by
// the single broadcast path into the chain and leaves by the single exit at
// cell zero. Elements that arrive while all cells are full are discarded,
// and every result of that batch carries the dropped flag. The final result
// of a batch, its largest element, carries final_res.
// ----------------------------------------------------------------------------
module heap_sort_engine (
	input  logic           clk,
	input  logic           arst_n,
	// input channel
	input  logic           in_valid,
	output logic           in_stall,
	input  hse_pkg::word_t value,
	input  logic           last,
	// output channel
	output logic           out_valid,
	input  logic           out_stall,
	output hse_pkg::word_t sorted_value,
	output logic           final_res,
	output logic           dropped
);

	// Chain signals. Each cell sees its neighbors through these arrays, with
	// fixed padding at both ends of the chain.
	hse_pkg::word_t           cell_value [hse_pkg::DEPTH];
	logic [hse_pkg::DEPTH-1:0] cell_valid;
	logic [hse_pkg::DEPTH-1:0] cell_lt;
	hse_pkg::word_t           left_value [hse_pkg::DEPTH];
	logic [hse_pkg::DEPTH-1:0] left_valid;
	logic [hse_pkg::DEPTH-1:0] left_lt;
	hse_pkg::word_t           right_value [hse_pkg::DEPTH];
	logic [hse_pkg::DEPTH-1:0] right_valid;

	hse_pkg::chain_ctrl_t ctrl;

	// Control state: draining a finished batch, and overflow seen in it.
	logic drain_q;
	logic ovf_q;

	logic in_take;
	logic out_take;
	logic chain_full;

	// The input is refused for the whole drain, so loading and draining never
	// overlap and the chain holds exactly one batch.
	assign in_stall   = drain_q;
	assign in_take    = in_valid && !drain_q;
	assign chain_full = cell_valid[hse_pkg::DEPTH-1];

	// Cell zero always holds the smallest element left, so it is the output.
	assign out_valid    = drain_q && cell_valid[0];
	assign sorted_value = cell_value[0];
	assign final_res    = cell_valid[0] && !cell_valid[1];
	assign dropped      = ovf_q;
	assign out_take     = out_valid && !out_stall;

	assign ctrl.insert = in_take && !chain_full;
	assign ctrl.shift  = out_take;

	// Neighbor wiring. The first cell has no smaller neighbor, so it takes
	// the broadcast element whenever it is the insertion point. The last cell
	// pulls in an empty slot when the chain shifts.
	always_comb begin
		left_value[0] = value;
		left_valid[0] = 1'b0;
		left_lt[0]    = 1'b0;
		for (int i = 1; i < hse_pkg::DEPTH; i++) begin
			left_value[i] = cell_value[i-1];
			left_valid[i] = cell_valid[i-1];
			left_lt[i]    = cell_lt[i-1];
		end
		for (int i = 0; i < hse_pkg::DEPTH - 1; i++) begin
			right_value[i] = cell_value[i+1];
			right_valid[i] = cell_valid[i+1];
		end
		right_value[hse_pkg::DEPTH-1] = '0;
		right_valid[hse_pkg::DEPTH-1] = 1'b0;
	end

	for (genvar g = 0; g < hse_pkg::DEPTH; g++) begin : g_cell
		hse_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.new_value   (value),
			.left_value  (left_value[g]),
			.left_valid  (left_valid[g]),
			.left_lt     (left_lt[g]),
			.right_value (right_value[g]),
			.right_valid (right_valid[g]),
			.cell_value  (cell_value[g]),
			.cell_valid  (cell_valid[g]),
			.cell_lt     (cell_lt[g])
		);
	end

	// Batch control. The last transaction starts the drain even when its
	// element was discarded; the batch is never empty because an element is only
	// discarded when every cell is full. Taking the final result returns to loading.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_q <= 1'b0;
			ovf_q   <= 1'b0;
		end else if (drain_q) begin
			if (out_take && final_res) begin
				drain_q <= 1'b0;
				ovf_q   <= 1'b0;
			end
		end else if (in_take) begin
			if (chain_full) begin
				ovf_q <= 1'b1;
			end
			if (last) begin
				drain_q <= 1'b1;
			end
		end
	end

`ifndef SYNTH
	// The occupied cells always form one unbroken run starting at cell zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot({1'b0, cell_valid} + {{hse_pkg::DEPTH{1'b0}}, 1'b1}))
		else $error("occupied cells are not a contiguous prefix of the chain");

	// Results come out in ascending order within a batch.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_take && !final_res |=> out_valid && (sorted_value >= $past(sorted_value)))
		else $error("results of a batch are not in ascending order");

	// After the final result the chain is empty and no result is offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_take && final_res |=> !out_valid && !in_stall && (cell_valid == '0))
		else $error("chain not empty after the final result");

	// Results are offered only while the input is held off.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("result offered while input transactions are taken");
`endif

endmodule

// ----- rtl/core/hse_cell.sv -----
// ----------------------------------------------------------------------------
// hse_cell: one storage cell of the sorting chain
// Holds one element and a valid bit, takes part in a parallel insertion, and
// passes its element toward the output end when the chain shifts.
// ----------------------------------------------------------------------------
module hse_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  hse_pkg::chain_ctrl_t ctrl,
	input  hse_pkg::word_t      new_value,
	input  hse_pkg::word_t      left_value,
	input  logic                left_valid,
	input  logic                left_lt,
	input  hse_pkg::word_t      right_value,
	input  logic                right_valid,
	output hse_pkg::word_t      cell_value,
	output logic                cell_valid,
	output logic                cell_lt
);

	hse_pkg::word_t value_q;
	logic           valid_q;

	// An empty cell counts as larger than any element, so the valid cells
	// always form a sorted prefix of the chain.
	assign cell_lt    = !valid_q || (new_value < value_q);
	assign cell_value = value_q;
	assign cell_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= right_valid;
		end else if (ctrl.insert && cell_lt) begin
			valid_q <= left_lt ? left_valid : 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			value_q <= right_value;
		end else if (ctrl.insert && cell_lt) begin
			value_q <= left_lt ? left_value : new_value;
		end
	end

endmodule

// ----- tb/hse_checker.sv -----
// ----------------------------------------------------------------------------
// hse_checker: result checker for the heap sort engine
// Watches both channels, keeps a sorted copy of every batch and compares each
// result transaction with the oldest value that is still owed.
// ----------------------------------------------------------------------------
module hse_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_stall,
	input  hse_pkg::word_t value,
	input  logic           last,
	input  logic           out_valid,
	input  logic           out_stall,
	input  hse_pkg::word_t sorted_value,
	input  logic           final_res,
	input  logic           dropped,
	output int             fail_count,
	output int             results_owed
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		hse_pkg::word_t value;
		logic           is_final;
		logic           is_dropped;
	} sorted_item_t;

	sorted_item_t owed_q[$];

	// Elements of the open batch, always kept in ascending order.
	hse_pkg::word_t held_elems [hse_pkg::DEPTH];
	int             held_count;
	logic           batch_overflow;

	// Takes one element into the open batch; on the last one, the whole batch
	// becomes owed results, smallest first.
	task automatic absorb_element(input hse_pkg::word_t v, input logic is_last);
		int           slot;
		int           k;
		sorted_item_t item;
		if (held_count < hse_pkg::DEPTH) begin
			slot = held_count;
			while (slot > 0 && held_elems[slot-1] > v) begin
				held_elems[slot] = held_elems[slot-1];
				slot--;
			end
			held_elems[slot] = v;
			held_count++;
		end else begin
			batch_overflow = 1'b1;
		end
		if (is_last) begin
			for (k = 0; k < held_count; k++) begin
				item.value      = held_elems[k];
				item.is_final   = (k == held_count - 1);
				item.is_dropped = batch_overflow;
				owed_q.push_back(item);
			end
			held_count     = 0;
			batch_overflow = 1'b0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		sorted_item_t want;
		if (!arst_n) begin
			owed_q.delete();
			held_count     = 0;
			batch_overflow = 1'b0;
			fail_count     = 0;
		end else begin
			// Results are checked before the input side is absorbed, so a
			// result can never match an element taken at the same edge.
			if (out_valid && !out_stall) begin
				if (owed_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result: sorted_value=%0d final_res=%0b dropped=%0b",
							sorted_value, final_res, dropped);
				end else begin
					want = owed_q.pop_front();
					if (sorted_value !== want.value || final_res !== want.is_final ||
							dropped !== want.is_dropped) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
								want.value, want.is_final, want.is_dropped,
								sorted_value, final_res, dropped);
					end
				end
			end
			if (in_valid && !in_stall)
				absorb_element(value, last);
		end
		results_owed = owed_q.size();
	end

endmodule

// ----- tb/tb_heap_sort_engine.sv -----
// ----------------------------------------------------------------------------
// tb_heap_sort_engine: testbench top for the heap sort engine
// Drives batches of signed elements, stalls the result side and gives the
// verdict from the failure count of the checker.
// ----------------------------------------------------------------------------
module tb_heap_sort_engine;
	timeunit 1ns;
	timeprecision 1ps;

	// Random phase stops once this many element transactions have been sent.
	localparam int ITEM_TARGET  = 170;
	// Quiet cycles after the last owed result, to catch stray results.
	localparam int DRAIN_CYCLES = 200;
	// Hard stop of the run, far beyond the slowest legal run.
	localparam int LIMIT_NS     = 2_000_000;

	logic           clk          = 1'b0;
	logic           arst_n       = 1'b0;
	logic           in_valid     = 1'b0;
	logic           in_stall;
	hse_pkg::word_t value        = '0;
	logic           last         = 1'b0;
	logic           out_valid;
	logic           out_stall    = 1'b0;
	hse_pkg::word_t sorted_value;
	logic           final_res;
	logic           dropped;

	int fail_count;
	int results_owed;

	// Sender state: transactions left in the current burst.
	int burst_left  = 1;
	int items_sent  = 0;

	// Receiver state: the current stall behavior and the time left in it.
	int stall_phase = 0;
	int stall_mode  = 0;

	heap_sort_engine dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.value        (value),
		.last         (last),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sorted_value (sorted_value),
		.final_res    (final_res),
		.dropped      (dropped)
	);

	hse_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.value        (value),
		.last         (last),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sorted_value (sorted_value),
		.final_res    (final_res),
		.dropped      (dropped),
		.fail_count   (fail_count),
		.results_owed (results_owed)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Watchdog. If the engine hangs, the run ends here as a failure.
	initial begin
		#(LIMIT_NS);
		$display("simulation failed");
		$finish;
	end

	// The receiver picks one of four stall behaviors for a random stretch of
	// cycles: never stalling, stalling now and then, stalling most of the time,
	// or a fixed one-in-four pattern. This can put stalls on any result of a
	// drain, including the first and the final one.
	always @(posedge clk) begin
		if (stall_phase == 0) begin
			stall_mode  <= $urandom_range(0, 3);
			stall_phase <= $urandom_range(20, 80);
		end else begin
			stall_phase <= stall_phase - 1;
		end
		case (stall_mode)
			0: begin
				out_stall <= 1'b0;
			end
			1: begin
				out_stall <= ($urandom_range(0, 3) == 0);
			end
			2: begin
				out_stall <= ($urandom_range(0, 4) != 0);
			end
			default: begin
				out_stall <= (stall_phase[1:0] == 2'b00);
			end
		endcase
	end

	// Sends one element transaction and returns at the edge that accepted it.
	// The stall is looked at on the falling edge, where it is settled, and the
	// transaction is taken at the next rising edge. After a burst the sender
	// may drop valid for a random gap; a gap of zero keeps valid high, so the
	// next transaction follows back to back.
	task automatic send_element(input hse_pkg::word_t v, input logic is_last);
		int gap;
		in_valid <= 1'b1;
		value    <= v;
		last     <= is_last;
		do @(negedge clk); while (in_stall);
		@(posedge clk);
		items_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
				: $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Holds the sender off until every owed result has been seen.
	task automatic wait_until_drained();
		in_valid <= 1'b0;
		do @(negedge clk); while (results_owed != 0);
		@(posedge clk);
	endtask

	// Small numbers, so that equal values are common, some extremes, and mostly
	// plain random words so that every bit takes both values.
	function automatic hse_pkg::word_t pick_value();
		case ($urandom_range(0, 9)) inside
			0: begin
				case ($urandom_range(0, 3))
					0:       return 32'sh8000_0000;
					1:       return 32'sh7fff_ffff;
					2:       return -32'sd1;
					default: return 32'sd0;
				endcase
			end
			[1:3]: begin
				return $signed(32'($urandom_range(0, 8))) - 32'sd4;
			end
			default: begin
				return $signed($urandom());
			end
		endcase
	endfunction

	initial begin
		int batch_idx;
		int batch_len;
		int k;

		// Reset once, released on a rising edge.
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. A batch of one element, the smallest value.
		send_element(32'sh8000_0000, 1'b1);
		// Two elements, extremes in descending order.
		send_element(32'sh7fff_ffff, 1'b0);
		send_element(32'sh8000_0000, 1'b1);
		// Extremes, zero, minus one and duplicates in one batch.
		send_element(32'sd0, 1'b0);
		send_element(-32'sd1, 1'b0);
		send_element(32'sh7fff_ffff, 1'b0);
		send_element(32'sh8000_0000, 1'b0);
		send_element(32'sd5, 1'b0);
		send_element(32'sd5, 1'b0);
		send_element(-32'sd5, 1'b0);
		send_element(32'sd1, 1'b0);
		send_element(32'sh7fff_ffff, 1'b0);
		send_element(32'sh8000_0000, 1'b1);
		// All values equal.
		send_element(32'sd7, 1'b0);
		send_element(32'sd7, 1'b0);
		send_element(32'sd7, 1'b1);
		// Descending run, so every insertion lands at the front.
		send_element(32'sd3, 1'b0);
		send_element(32'sd2, 1'b0);
		send_element(32'sd1, 1'b0);
		send_element(32'sd0, 1'b1);

		// The sender waits here for the whole directed part to come out.
		wait_until_drained();

		// Random part. Mostly small batches; one batch overflows the store
		// by a few elements, so the last transaction is itself discarded, and
		// one batch fills it exactly.
		batch_idx = 0;
		while (items_sent < ITEM_TARGET) begin
			if (batch_idx == 2)
				batch_len = hse_pkg::DEPTH + $urandom_range(1, 3);
			else if (batch_idx == 9)
				batch_len = hse_pkg::DEPTH;
			else
				batch_len = $urandom_range(1, 8);
			for (k = 0; k < batch_len; k++)
				send_element(pick_value(), k == batch_len - 1);
			if (batch_idx == 5)
				wait_until_drained();
			batch_idx++;
		end

		wait_until_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0 && results_owed == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
